@@ sv/local_entropy_filter_defines.svh @@
// Assertion macros shared by the local entropy filter RTL.
`ifndef LOCAL_ENTROPY_FILTER_DEFINES_SVH
`define LOCAL_ENTROPY_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LEF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LEF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/lef_pkg.sv @@
// Constants, types and the log2 table of the local entropy filter.
package lef_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int RADIUS     = 4;
   localparam int BINS       = 16;
   localparam int ROWS_KEPT  = 10;
   localparam int FRAC       = 30;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int SLOT_W  = $clog2(ROWS_KEPT);
   localparam int BIN_W   = $clog2(BINS);
   localparam int DIM_W   = 11;
   localparam int ADDR_W  = SLOT_W + COL_W;
   localparam int DEPTH   = ROWS_KEPT * MAX_WIDTH;
   localparam int CNT_W   = 7;
   localparam int LOG_W   = 34;
   localparam int TERM_W  = CNT_W + LOG_W;
   localparam int NUM_W   = TERM_W + 14;
   localparam int QUO_W   = 16;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef logic [LOG_W-1:0] log_tab_type [0:(1<<CNT_W)-1];

   // log2 in Q30: exact integer part, then one fraction bit per truncated square
   function automatic logic [LOG_W-1:0] log2_q30(input logic [CNT_W-1:0] x);
      logic [63:0] y;
      logic [LOG_W-1:0] res;
      int k;
      int i;
      begin
         res = '0;
         if (x != '0) begin
            k = 0;
            while (k < CNT_W - 1 && (x >> (k + 1)) != '0) k++;
            y = 64'(x) << (FRAC - k);
            res = LOG_W'(k) << FRAC;
            for (i = FRAC - 1; i >= 0; i--) begin
               y = (y * y) >> FRAC;
               if (y >= (64'd2 << FRAC)) begin
                  y = y >> 1;
                  res[i] = 1'b1;
               end
            end
         end
         return res;
      end
   endfunction

   function automatic log_tab_type build_log_tab();
      log_tab_type t;
      int j;
      begin
         for (j = 0; j < (1 << CNT_W); j++) t[j] = log2_q30(CNT_W'(j));
         return t;
      end
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [CNT_W-1:0] count;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quot;
   } div_rsp_type;

endpackage

@@ sv/lef_divider.sv @@
// Bit-serial divider: entropy sum over count times 2^30, saturating at 16 bits.
module lef_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  lef_pkg::div_req_type div_req,
   output lef_pkg::div_rsp_type div_rsp
);

   localparam int DVS_W = lef_pkg::CNT_W + lef_pkg::FRAC + lef_pkg::QUO_W - 1;

   logic [lef_pkg::NUM_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0]          dvs_ff, dvs_in;
   logic [lef_pkg::QUO_W-1:0] quot_ff, quot_in;
   logic [3:0]                step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [lef_pkg::NUM_W-1:0] sat_lim;
   logic                      fits;

   assign sat_lim = lef_pkg::NUM_W'({lef_pkg::CNT_W'(div_req.count),
                                     (lef_pkg::FRAC + lef_pkg::QUO_W)'(0)});
   assign fits    = rem_ff >= lef_pkg::NUM_W'(dvs_ff);

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         if (div_req.num >= sat_lim) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = div_req.num;
            dvs_in  = {div_req.count, (DVS_W - lef_pkg::CNT_W)'(0)};
            quot_in = '0;
            step_in = 4'(lef_pkg::QUO_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (fits) rem_in = rem_ff - lef_pkg::NUM_W'(dvs_ff);
         quot_in = {quot_ff[lef_pkg::QUO_W-2:0], fits};
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff - 4'd1;
         if (step_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

@@ sv/local_entropy_filter.sv @@
// Local entropy filter top level: line store, window scan, entropy terms and output.
// Each beat on req_ takes one pixel (or a drain tick); the block then stalls the input
// while it decides whether one more centre has a complete window and, if so, works it
// out. Working out a result reads the clipped window (up to 81 pixels for a full 9x9)
// from the line store one bin a cycle, takes one histogram bin a cycle through a
// shared multiply-accumulate, and ends in a 16-step serial divider. A finished result
// waits in the rsp_ register while the next beat is taken. Register writes are taken
// only while the block is idle, and writing either register abandons the frame.
`include "local_entropy_filter_defines.svh"

module local_entropy_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_pixel_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_entropy_value,
   output logic        rsp_last_of_frame,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   localparam int DW = lef_pkg::DIM_W;
   localparam int SW = lef_pkg::SLOT_W;
   localparam int CW = lef_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_SCAN, ST_FLUSH, ST_TERMS, ST_START, ST_DIV, ST_OUT
   } state_type;

   state_type state_ff;

   logic [DW-1:0] width_ff, height_ff;
   logic [DW-1:0] in_row_ff, in_col_ff, out_row_ff, out_col_ff;
   logic [SW-1:0] in_slot_ff, out_slot_ff;
   logic [DW-1:0] y_ff, x_ff, r1_ff, c0_ff, c1_ff;
   logic [SW-1:0] y_slot_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] hist_ff [lef_pkg::BINS];
   logic [lef_pkg::BIN_W-1:0] b_ff, rd_bin_ff;
   logic          rd_valid_ff;
   logic [lef_pkg::TERM_W-1:0] total_ff, sub_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [15:0]   rsp_value_ff;
   logic [lef_pkg::BIN_W-1:0] mem [lef_pkg::DEPTH];

   logic          accept, in_full, ready_now, last_out;
   logic [DW-1:0] nr, nc, r0, c0, out_row_p4, out_col_p4, csr_clamped;
   logic [SW-1:0] r0_slot;
   logic [CW-1:0] cur_f, mul_f;
   logic [lef_pkg::TERM_W-1:0] s_val, mul_p;
   lef_pkg::div_req_type div_req;
   lef_pkg::div_rsp_type div_rsp;

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign in_full   = in_row_ff >= height_ff;

   assign out_row_p4 = out_row_ff + DW'(lef_pkg::RADIUS);
   assign out_col_p4 = out_col_ff + DW'(lef_pkg::RADIUS);
   assign nr = (out_row_p4 < height_ff) ? out_row_p4 : height_ff - DW'(1);
   assign nc = (out_col_p4 < width_ff) ? out_col_p4 : width_ff - DW'(1);
   assign r0 = (out_row_ff >= DW'(lef_pkg::RADIUS)) ? out_row_ff - DW'(lef_pkg::RADIUS) : '0;
   assign c0 = (out_col_ff >= DW'(lef_pkg::RADIUS)) ? out_col_ff - DW'(lef_pkg::RADIUS) : '0;
   assign r0_slot = (out_row_ff < DW'(lef_pkg::RADIUS)) ? '0 :
                    (out_slot_ff >= SW'(lef_pkg::RADIUS)) ? out_slot_ff - SW'(lef_pkg::RADIUS) :
                    out_slot_ff + SW'(lef_pkg::ROWS_KEPT - lef_pkg::RADIUS);
   assign ready_now = (in_row_ff > nr) || (in_row_ff == nr && in_col_ff > nc);
   assign last_out  = (out_row_ff == height_ff - DW'(1)) && (out_col_ff == width_ff - DW'(1));

   assign cur_f = hist_ff[b_ff];
   assign s_val = (total_ff >= sub_ff) ? total_ff - sub_ff : '0;

   // one multiplier serves n*log2(n) and every f*log2(f) term
   assign mul_f = (state_ff == ST_FLUSH) ? n_ff : cur_f;
   assign mul_p = lef_pkg::TERM_W'(mul_f) * lef_pkg::TERM_W'(lef_pkg::LOG_TAB[mul_f]);

   assign div_req.start = state_ff == ST_START;
   assign div_req.num   = (lef_pkg::NUM_W'(s_val) << 13) + (lef_pkg::NUM_W'(n_ff) << 29);
   assign div_req.count = n_ff;

   // width and height of zero act as one, above the maximum as the maximum
   assign csr_clamped = (csr_data == '0) ? DW'(1) :
                        (csr_data > DW'(lef_pkg::MAX_WIDTH)) ? DW'(lef_pkg::MAX_WIDTH) : csr_data;

   lef_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // line store; bin is the top nibble (floor(v*16/255) differs only at 255, which clamps)
   always_ff @(posedge clock) begin
      if (accept && req_cmd == lef_pkg::CMD_PIXEL && !in_full)
         mem[{in_slot_ff, in_col_ff[lef_pkg::COL_W-1:0]}] <= req_pixel_value[7:4];
      rd_bin_ff <= mem[{y_slot_ff, x_ff[lef_pkg::COL_W-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= DW'(640);
         height_ff    <= DW'(480);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_slot_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lef_pkg::BINS; i++) hist_ff[i] <= '0;
      end else begin
         // the output state sets valid itself, so drop it only elsewhere
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         rd_valid_ff <= state_ff == ST_SCAN;
         for (int i = 0; i < lef_pkg::BINS; i++)
            if (rd_valid_ff && rd_bin_ff == lef_pkg::BIN_W'(i)) hist_ff[i] <= hist_ff[i] + CW'(1);

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_cmd == lef_pkg::CMD_PIXEL && !in_full) begin
                     if (in_col_ff == width_ff - DW'(1)) begin
                        in_col_ff  <= '0;
                        in_row_ff  <= in_row_ff + DW'(1);
                        in_slot_ff <= (in_slot_ff == SW'(lef_pkg::ROWS_KEPT - 1)) ? '0 :
                                      in_slot_ff + SW'(1);
                     end else begin
                        in_col_ff <= in_col_ff + DW'(1);
                     end
                  end
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (ready_now) begin
                  y_ff      <= r0;
                  y_slot_ff <= r0_slot;
                  x_ff      <= c0;
                  c0_ff     <= c0;
                  r1_ff     <= nr;
                  c1_ff     <= nc;
                  n_ff      <= CW'((nr - r0 + DW'(1)) * (nc - c0 + DW'(1)));
                  for (int i = 0; i < lef_pkg::BINS; i++) hist_ff[i] <= '0;
                  state_ff  <= ST_SCAN;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               if (x_ff == c1_ff) begin
                  x_ff <= c0_ff;
                  if (y_ff == r1_ff) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     y_ff      <= y_ff + DW'(1);
                     y_slot_ff <= (y_slot_ff == SW'(lef_pkg::ROWS_KEPT - 1)) ? '0 :
                                  y_slot_ff + SW'(1);
                  end
               end else begin
                  x_ff <= x_ff + DW'(1);
               end
            end
            ST_FLUSH: begin
               total_ff <= mul_p;
               sub_ff   <= '0;
               b_ff     <= '0;
               state_ff <= ST_TERMS;
            end
            ST_TERMS: begin
               sub_ff <= sub_ff + mul_p;
               b_ff   <= b_ff + lef_pkg::BIN_W'(1);
               if (b_ff == lef_pkg::BIN_W'(lef_pkg::BINS - 1)) state_ff <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_rsp.done) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // hold until the previous result has left
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= div_rsp.quot;
                  rsp_last_ff  <= last_out;
                  if (last_out) begin
                     in_row_ff   <= '0;
                     in_col_ff   <= '0;
                     in_slot_ff  <= '0;
                     out_row_ff  <= '0;
                     out_col_ff  <= '0;
                     out_slot_ff <= '0;
                  end else if (out_col_ff == width_ff - DW'(1)) begin
                     out_col_ff  <= '0;
                     out_row_ff  <= out_row_ff + DW'(1);
                     out_slot_ff <= (out_slot_ff == SW'(lef_pkg::ROWS_KEPT - 1)) ? '0 :
                                    out_slot_ff + SW'(1);
                  end else begin
                     out_col_ff <= out_col_ff + DW'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // a register write abandons the frame
         if (csr_valid && csr_ready) begin
            unique case (lef_pkg::csr_index_type'(csr_index))
               lef_pkg::CSR_IMAGE_WIDTH:  width_ff <= csr_clamped;
               lef_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_clamped;
               default: ;
            endcase
            in_row_ff   <= '0;
            in_col_ff   <= '0;
            in_slot_ff  <= '0;
            out_row_ff  <= '0;
            out_col_ff  <= '0;
            out_slot_ff <= '0;
            for (int i = 0; i < lef_pkg::BINS; i++) hist_ff[i] <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entropy_value = rsp_value_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   `LEF_ASSERT_NOW(a_in_in_frame, 1'b1, (in_row_ff < height_ff) || (in_col_ff == '0), "input position past frame")
   `LEF_ASSERT_NOW(a_out_behind_in, 1'b1, out_row_ff <= in_row_ff, "output overtook input")
   `LEF_ASSERT_NOW(a_div_done_waited, div_rsp.done, state_ff == ST_DIV, "divider done outside wait")
   `LEF_ASSERT_NEXT(a_scan_ends_flush, state_ff == ST_FLUSH, state_ff == ST_TERMS && !rd_valid_ff, "scan flush broken")

endmodule
